// ===== rtl/llacc_pkg.sv =====
// Shared constants, types and the log-sigmoid correction curve of the log-likelihood accumulator.
package llacc_pkg;

	// Coefficient store geometry.
	localparam int MAX_FEATURES = 256;
	localparam int ADDR_W       = $clog2(MAX_FEATURES);

	// Correction curve: CURVE_ENTRIES intervals over |x| in [0,16].
	localparam int CURVE_ENTRIES = 256;
	localparam int CIDX_W        = $clog2(CURVE_ENTRIES + 1);
	localparam int CURVE_W       = 16;
	// |x| below 16.0 in Q16.16 has 20 bits.
	localparam int RANGE_BITS    = 20;

	// Fixed field widths.
	localparam int VAL_W  = 32;
	localparam int POS_W  = 8;
	localparam int CNT_W  = 9;
	localparam int SUM_W  = 48;
	localparam int TERM_W = 32;
	localparam int PROD_W = 2 * VAL_W;
	localparam int FRAC_W = 16;

	localparam logic [CNT_W-1:0] FEATURE_COUNT_RESET = 9'd256;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [TERM_W-1:0] TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};

	// Item kinds carried in the low tuser bit.
	localparam logic KIND_COEF    = 1'b0;
	localparam logic KIND_FEATURE = 1'b1;

	// Control from the sequencer to the dot-product unit.
	typedef struct packed {
		logic mul;       // capture feature times coefficient
		logic use_feat;  // the product counts toward the sum
		logic acc;       // add the captured product
		logic start;     // first feature of a sample: base is the intercept
	} dot_ctrl_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    sat;  // the accumulate of this cycle saturated
	} dot_stat_t;

	typedef struct packed {
		logic                    valid;
		logic                    neg;
		logic signed [SUM_W-1:0] eta;
	} lsig_req_t;

	typedef struct packed {
		logic                     valid;
		logic                     sat;
		logic signed [TERM_W-1:0] term;
	} lsig_res_t;

	typedef logic [CURVE_W-1:0] curve_t [CURVE_ENTRIES+1];

	localparam logic [63:0] LN2_Q30 = 64'd744261118;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	// Unsigned 64-bit quotient by restoring long division, used only while building the curve.
	function automatic logic [63:0] const_udiv(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		int          b;
		q   = 64'd0;
		rem = 65'd0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-u) with u and the result in Q30, series around a power-of-two split.
	function automatic logic [63:0] curve_exp_neg(logic [63:0] u);
		logic [63:0] m;
		logic [63:0] r;
		logic [63:0] term;
		longint      acc;
		int          n;
		m    = const_udiv(u, LN2_Q30);
		r    = u - m * LN2_Q30;
		term = ONE_Q30;
		acc  = longint'(ONE_Q30);
		for (n = 1; n <= 20; n++) begin
			term = const_udiv((term * r) >> 30, 64'(n));
			if (n[0])
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		if (m > 64'd62)
			return 64'd0;
		return 64'(acc) >> m;
	endfunction

	// ln(1+y) with y in Q30 within [0,1], through the atanh series.
	function automatic logic [63:0] curve_ln1p(logic [63:0] y);
		logic [63:0] s;
		logic [63:0] s2;
		logic [63:0] pw;
		logic [63:0] acc;
		int          n;
		s   = const_udiv(y << 30, 2 * ONE_Q30 + y);
		s2  = (s * s) >> 30;
		pw  = s;
		acc = 64'd0;
		for (n = 0; n < 16; n++) begin
			acc = acc + const_udiv(pw, 64'(2 * n + 1));
			pw  = (pw * s2) >> 30;
		end
		return 2 * acc;
	endfunction

	// Knots of ln(1+exp(-u)) rounded to nearest Q16.16, built at elaboration.
	function automatic curve_t build_curve();
		curve_t      c;
		logic [63:0] u;
		logic [63:0] v;
		int          k;
		for (k = 0; k <= CURVE_ENTRIES; k++) begin
			u    = (64'(k) << 34) >> $clog2(CURVE_ENTRIES);
			v    = curve_ln1p(curve_exp_neg(u));
			c[k] = CURVE_W'((v + (64'd1 << 13)) >> 14);
		end
		return c;
	endfunction

	localparam curve_t CURVE = build_curve();

endpackage

// ===== rtl/llacc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module llacc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/llacc_dot.sv =====
// Multiply-accumulate unit that builds the linear sum of one sample.
module llacc_dot import llacc_pkg::*; (
	input  logic                    clk,
	input  dot_ctrl_t               ctrl,
	input  logic signed [VAL_W-1:0] feat,
	input  logic signed [VAL_W-1:0] coef,
	input  logic signed [VAL_W-1:0] intercept,
	output dot_stat_t               stat
);

	logic signed [PROD_W-1:0] feat_x;
	logic signed [PROD_W-1:0] coef_x;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     use_s1;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  base;
	logic signed [SUM_W-1:0]  addend;
	logic signed [SUM_W:0]    raw;
	logic                     ovf;
	logic signed [SUM_W-1:0]  next_sum;

	assign feat_x = {{(PROD_W-VAL_W){feat[VAL_W-1]}}, feat};
	assign coef_x = {{(PROD_W-VAL_W){coef[VAL_W-1]}}, coef};

	// Product stage: one 32x32 signed multiply, registered.
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_s1 <= feat_x * coef_x;
			use_s1  <= ctrl.use_feat;
		end
	end

	// Accumulate stage: floor shift of the product, saturating 48-bit add.
	always_comb begin
		base     = ctrl.start ? {{(SUM_W-VAL_W){intercept[VAL_W-1]}}, intercept} : sum_q;
		addend   = use_s1 ? prod_s1[PROD_W-1:FRAC_W] : '0;
		raw      = {base[SUM_W-1], base} + {addend[SUM_W-1], addend};
		ovf      = raw[SUM_W] != raw[SUM_W-1];
		next_sum = raw[SUM_W-1:0];
		if (ovf)
			next_sum = raw[SUM_W] ? SUM_MIN : SUM_MAX;
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc)
			sum_q <= next_sum;
	end

	assign stat.sum = sum_q;
	assign stat.sat = ctrl.acc && ovf;

endmodule

// ===== rtl/llacc_lsig.sv =====
// Four-stage log-sigmoid evaluator with label sign, curve lookup and interpolation.
module llacc_lsig import llacc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lsig_req_t req,
	output lsig_res_t res
);

	localparam int P_W = RANGE_BITS + CIDX_W;

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [SUM_W-1:0] x_s1;
	logic                    sat_s1;

	logic [CIDX_W-1:0]       idx_s2;
	logic [RANGE_BITS-1:0]   frac_s2;
	logic                    rng_s2;
	logic signed [SUM_W-1:0] xmin_s2;
	logic                    sat_s2;

	logic [CURVE_W-1:0]      corr_s3;
	logic signed [SUM_W-1:0] xmin_s3;
	logic                    sat_s3;

	logic signed [TERM_W-1:0] term_s4;
	logic                     sat_s4;

	logic signed [SUM_W-1:0]  x_n;
	logic                     neg_sat;
	logic [SUM_W-1:0]         mag;
	logic [P_W-1:0]           p;
	logic [CURVE_W-1:0]       left;
	logic [CURVE_W-1:0]       right;
	logic [CURVE_W-1:0]       diff;
	logic [CURVE_W+RANGE_BITS-1:0] step_full;
	logic [CURVE_W-1:0]       step;
	logic [CURVE_W-1:0]       corr;
	logic signed [SUM_W:0]    term_full;
	logic                     term_fits;

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: apply the label; negating the most negative sum saturates.
	always_comb begin
		x_n     = req.eta;
		neg_sat = 1'b0;
		if (req.neg) begin
			if (req.eta == SUM_MIN) begin
				x_n     = SUM_MAX;
				neg_sat = 1'b1;
			end else begin
				x_n = -req.eta;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			x_s1   <= x_n;
			sat_s1 <= neg_sat;
		end
	end

	// Stage 2: magnitude, range check and split into knot index and fraction.
	always_comb begin
		mag = x_s1[SUM_W-1] ? SUM_W'(-x_s1) : SUM_W'(x_s1);
		p   = P_W'(mag[RANGE_BITS-1:0]) * P_W'(CURVE_ENTRIES);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			idx_s2  <= p[P_W-1:RANGE_BITS];
			frac_s2 <= p[RANGE_BITS-1:0];
			rng_s2  <= mag[SUM_W-1:RANGE_BITS] == '0;
			xmin_s2 <= x_s1[SUM_W-1] ? x_s1 : '0;
			sat_s2  <= sat_s1;
		end
	end

	// Stage 3: interpolate between the two knots, truncating toward the left one.
	always_comb begin
		left      = CURVE[idx_s2];
		right     = CURVE[idx_s2 + 1'b1];
		diff      = (left >= right) ? left - right : right - left;
		step_full = (CURVE_W+RANGE_BITS)'(diff) * (CURVE_W+RANGE_BITS)'(frac_s2);
		step      = step_full[CURVE_W+RANGE_BITS-1:RANGE_BITS];
		corr      = (left >= right) ? left - step : left + step;
		if (!rng_s2)
			corr = '0;
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			corr_s3 <= corr;
			xmin_s3 <= xmin_s2;
			sat_s3  <= sat_s2;
		end
	end

	// Stage 4: term = min(x,0) - correction, saturated to 32 bits.
	always_comb begin
		term_full = {xmin_s3[SUM_W-1], xmin_s3} - (SUM_W+1)'({1'b0, corr_s3});
		term_fits = (&term_full[SUM_W:TERM_W-1]) || !(|term_full[SUM_W:TERM_W-1]);
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			term_s4 <= term_fits ? term_full[TERM_W-1:0] : TERM_MIN;
			sat_s4  <= sat_s3 || !term_fits;
		end
	end

	assign res.valid = v_s4;
	assign res.sat   = sat_s4;
	assign res.term  = term_s4;

endmodule

// ===== rtl/logistic_loglik_accumulator.sv =====
// Top level of the logistic regression log-likelihood accumulator.
//
//  channel  | direction | payload                                        | handshake
//  s_axis   | in        | tdata: position, value, label, last_sample     | tvalid/tready
//           |           | tuser: kind, value_missing; tlast: last_feature|
//  m_axis   | out       | tdata: sample_term, running_total              | tvalid/tready
//           |           | tuser: saturated; tlast: set_done              |
//  cfg      | in        | data: feature_count                            | valid/ready
//
// A coefficient word is written at accept and the sequencer stays ready; a feature word
// takes the coefficient RAM read with the multiply, then the accumulate into the linear sum.
// A last feature word has its result in the output register after the multiply-accumulate,
// the four stages of the log-sigmoid unit, the set total add and the output load; the next
// word is taken once the sequencer is back in idle at the earliest.
// A stalled output holds the sequencer before the next word.
// Reset clears control state; the coefficient RAM keeps no reset and needs no clear.
module logistic_loglik_accumulator import llacc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// s_axis_tdata: position[7:0], value[39:8], label[41:40], last_sample[42], zero[47:43]
	input  logic [47:0]       s_axis_tdata,
	// s_axis_tuser: kind[0], value_missing[1]
	input  logic [1:0]        s_axis_tuser,
	input  logic              s_axis_tlast,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// m_axis_tdata: sample_term[31:0], running_total[79:32]
	output logic [79:0]       m_axis_tdata,
	// m_axis_tuser: saturated[0]
	output logic              m_axis_tuser,
	output logic              m_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic              cfg_valid,
	output logic              cfg_ready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_GO,
		S_WAIT,
		S_OUT
	} state_t;

	state_t state_q;

	logic                     in_acc;
	logic                     in_kind;
	logic                     in_missing;
	logic [POS_W-1:0]         in_pos;
	logic signed [VAL_W-1:0]  in_val;
	logic [1:0]               in_label;
	logic                     in_last_s;

	logic [POS_W-1:0]         pos_q;
	logic signed [VAL_W-1:0]  val_q;
	logic                     missing_q;
	logic                     neg_q;
	logic                     last_f_q;
	logic                     last_s_q;
	logic signed [VAL_W-1:0]  intercept_q;
	logic [CNT_W-1:0]         fc_q;

	logic                     open_q;
	logic                     sat_seen_q;
	logic signed [SUM_W-1:0]  set_total_q;
	logic signed [SUM_W-1:0]  total_s_q;
	logic signed [TERM_W-1:0] term_s_q;
	logic                     m_valid_q;
	logic signed [TERM_W-1:0] m_term_q;
	logic signed [SUM_W-1:0]  m_total_q;
	logic                     m_done_q;
	logic                     m_sat_q;

	logic                     ram_we;
	logic                     ram_re;
	logic [VAL_W-1:0]         ram_rdata;
	dot_ctrl_t                dot_ctrl;
	dot_stat_t                dot_stat;
	lsig_req_t                lsig_req;
	lsig_res_t                lsig_res;

	logic signed [SUM_W:0]    tot_raw;
	logic                     tot_ovf;
	logic signed [SUM_W-1:0]  tot_next;

	// Input word fields.
	assign in_kind    = s_axis_tuser[0];
	assign in_missing = s_axis_tuser[1];
	assign in_pos     = s_axis_tdata[7:0];
	assign in_val     = s_axis_tdata[39:8];
	assign in_label   = s_axis_tdata[41:40];
	assign in_last_s  = s_axis_tdata[42];

	assign s_axis_tready = (state_q == S_IDLE) || (state_q == S_ACC && !last_f_q);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Coefficient RAM: writes go in at accept, feature reads issue at accept.
	assign ram_we = in_acc && in_kind == KIND_COEF && 32'(in_pos) < MAX_FEATURES;
	assign ram_re = in_acc && in_kind == KIND_FEATURE;

	llacc_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_FEATURES)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(in_pos)),
		.wdata (in_val),
		.re    (ram_re),
		.raddr (ADDR_W'(in_pos)),
		.rdata (ram_rdata)
	);

	// Word capture and the intercept copy for the start of a sample.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q     <= in_pos;
			val_q     <= in_val;
			missing_q <= in_missing;
			neg_q     <= in_label[1];
			last_f_q  <= s_axis_tlast;
			last_s_q  <= in_last_s;
		end
		if (in_acc && in_kind == KIND_COEF && in_pos == '0)
			intercept_q <= in_val;
	end

	// Feature count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fc_q <= FEATURE_COUNT_RESET;
		else if (cfg_valid && cfg_ready)
			fc_q <= cfg_data;
	end

	// Linear sum datapath.
	always_comb begin
		dot_ctrl.mul      = state_q == S_MUL;
		dot_ctrl.use_feat = !missing_q && pos_q != '0 && {1'b0, pos_q} < fc_q
			&& 32'(pos_q) < MAX_FEATURES;
		dot_ctrl.acc      = state_q == S_ACC;
		dot_ctrl.start    = !open_q;
	end

	llacc_dot u_dot (
		.clk       (clk),
		.ctrl      (dot_ctrl),
		.feat      (val_q),
		.coef      (ram_rdata),
		.intercept (intercept_q),
		.stat      (dot_stat)
	);

	// Log-sigmoid of the labeled sum.
	assign lsig_req.valid = state_q == S_GO;
	assign lsig_req.neg   = neg_q;
	assign lsig_req.eta   = dot_stat.sum;

	llacc_lsig u_lsig (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lsig_req),
		.res    (lsig_res)
	);

	// Saturating set total.
	always_comb begin
		tot_raw  = {set_total_q[SUM_W-1], set_total_q}
			+ (SUM_W+1)'(lsig_res.term);
		tot_ovf  = tot_raw[SUM_W] != tot_raw[SUM_W-1];
		tot_next = tot_raw[SUM_W-1:0];
		if (tot_ovf)
			tot_next = tot_raw[SUM_W] ? SUM_MIN : SUM_MAX;
	end

	// Sequencer, sample state, set total and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			open_q      <= 1'b0;
			sat_seen_q  <= 1'b0;
			set_total_q <= '0;
			total_s_q   <= '0;
			term_s_q    <= '0;
			m_valid_q   <= 1'b0;
			m_term_q    <= '0;
			m_total_q   <= '0;
			m_done_q    <= 1'b0;
			m_sat_q     <= 1'b0;
		end else begin
			// The output word leaves here unless a new one replaces it below.
			if (m_valid_q && m_axis_tready && state_q != S_OUT)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_kind == KIND_FEATURE)
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					open_q     <= !last_f_q;
					sat_seen_q <= (open_q && sat_seen_q) || dot_stat.sat;
					if (last_f_q)
						state_q <= S_GO;
					else if (in_acc && in_kind == KIND_FEATURE)
						state_q <= S_MUL;
					else
						state_q <= S_IDLE;
				end
				S_GO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (lsig_res.valid) begin
						sat_seen_q  <= sat_seen_q || lsig_res.sat || tot_ovf;
						total_s_q   <= tot_next;
						term_s_q    <= lsig_res.term;
						set_total_q <= last_s_q ? '0 : tot_next;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_term_q  <= term_s_q;
						m_total_q <= total_s_q;
						m_done_q  <= last_s_q;
						m_sat_q   <= sat_seen_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_total_q, m_term_q};
	assign m_axis_tlast  = m_done_q;
	assign m_axis_tuser  = m_sat_q;

endmodule

// ===== rtl/llacc_checker.sv =====
// Port-level checks of the log-likelihood accumulator, bound to the top level.
module llacc_checker import llacc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic [1:0]  s_axis_tuser,
	input logic        s_axis_tlast,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready
);

	// A log-sigmoid term is never positive.
	a_term_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31] || m_axis_tdata[31:0] == '0))
		else $error("sample term above zero");

	// The running total of non-positive terms is never positive.
	a_total_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[79] || m_axis_tdata[79:32] == '0))
		else $error("running total above zero");

	// The word after a closing feature is held off while the sample is evaluated.
	a_close_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast && s_axis_tuser[0] == KIND_FEATURE)
		|=> !s_axis_tready)
		else $error("input taken right after a closing feature");

	// A new result never follows an input word in the cycle before.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared too soon after an input word");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind logistic_loglik_accumulator llacc_checker u_llacc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tuser  (s_axis_tuser),
	.s_axis_tlast  (s_axis_tlast),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the logistic regression log-likelihood accumulator.
`timescale 1ns / 100ps

module tb_top;
	import llacc_pkg::*;

	// Run timing.
	localparam int     SETTLE_CYCLES = 40;
	localparam int     HOLD_CYCLES   = 400;
	localparam longint RUN_LIMIT_NS  = 4_000_000;

	// Correction curve geometry and its series constants, in Q30.
	localparam int          KNOTS       = 256;
	localparam int          INTERP_BITS = 20;
	localparam logic [63:0] Q30_LN2     = 64'd744261118;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	// Label codes: only the sign bit matters.
	localparam logic signed [1:0] LABEL_PLUS   = 2'sb01;
	localparam logic signed [1:0] LABEL_ZERO   = 2'sb00;
	localparam logic signed [1:0] LABEL_MINUS  = 2'sb11;
	localparam logic signed [1:0] LABEL_MINUS2 = 2'sb10;

	typedef struct {
		logic                kind;
		logic [7:0]          position;
		logic signed [31:0]  value;
		logic                missing;
		logic signed [1:0]   label;
		logic                last_feature;
		logic                last_sample;
	} llacc_word_t;

	typedef struct {
		logic signed [31:0] term;
		logic signed [47:0] total;
		logic               set_done;
		logic               saturated;
	} llacc_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic [47:0]      s_axis_tdata  = '0;
	logic [1:0]       s_axis_tuser  = '0;
	logic             s_axis_tlast  = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [79:0]      m_axis_tdata;
	logic             m_axis_tuser;
	logic             m_axis_tlast;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [CNT_W-1:0] cfg_data      = '0;
	logic             cfg_valid     = 1'b0;
	logic             cfg_ready;

	// Predictor state.
	longint             knots [0:KNOTS];
	logic signed [31:0] coef_mem [256];
	logic [8:0]         fc_model      = 9'd256;
	longint             lin_sum       = 0;
	bit                 sample_active = 1'b0;
	longint             set_sum       = 0;
	bit                 sat_seen      = 1'b0;
	llacc_result_t      expected_results [$];

	// Traffic shaping and bookkeeping.
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_left      = 0;
	logic hold_req       = 1'b0;
	logic hold_ack       = 1'b0;
	int   errors         = 0;
	int   words_sent     = 0;
	int   results_seen   = 0;
	int   sets_closed    = 0;
	int   sat_flagged    = 0;
	int   in_stalls      = 0;

	logistic_loglik_accumulator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_data      (cfg_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready)
	);

	always #6 clk = ~clk;

	// Knots of ln(1+exp(-u)) over u in [0,16], from integer series in Q30.
	initial begin : knot_build
		logic [63:0] u, m, r, t, y, s, s2, pw, v;
		longint      acc;
		int          k, n;
		for (k = 0; k <= KNOTS; k++) begin
			u = (64'(k) << 34) / KNOTS;
			m = u / Q30_LN2;
			r = u - m * Q30_LN2;
			t = Q30_ONE;
			acc = longint'(Q30_ONE);
			for (n = 1; n <= 20; n++) begin
				t = ((t * r) >> 30) / 64'(n);
				if (n % 2 == 1)
					acc -= longint'(t);
				else
					acc += longint'(t);
			end
			if (acc < 0)
				acc = 0;
			y = (m > 64'd62) ? 64'd0 : (64'(acc) >> m);
			s = (y << 30) / (2 * Q30_ONE + y);
			s2 = (s * s) >> 30;
			pw = s;
			v = 64'd0;
			for (n = 0; n < 16; n++) begin
				v += pw / 64'(2 * n + 1);
				pw = (pw * s2) >> 30;
			end
			v = 2 * v;
			knots[k] = longint'((v + (64'd1 << 13)) >> 14);
		end
	end

	// Saturate a sum to 48 bits and remember that it happened.
	function automatic longint clamp48(input longint v);
		if (v > longint'(SUM_MAX)) begin
			sat_seen = 1'b1;
			return longint'(SUM_MAX);
		end
		if (v < longint'(SUM_MIN)) begin
			sat_seen = 1'b1;
			return longint'(SUM_MIN);
		end
		return v;
	endfunction

	// log(sigmoid(x)) = min(x,0) - correction, correction interpolated between knots.
	function automatic longint log_sigmoid_q16(input longint x);
		longint mag, p, idx, frac, left, right, corr, res;
		corr = 0;
		mag = (x < 0) ? -x : x;
		if (mag < (longint'(16) << 16)) begin
			p = mag * KNOTS;
			idx = p >>> INTERP_BITS;
			frac = p & ((longint'(1) << INTERP_BITS) - 1);
			left = knots[idx];
			right = knots[idx + 1];
			if (left >= right)
				corr = left - (((left - right) * frac) >>> INTERP_BITS);
			else
				corr = left + (((right - left) * frac) >>> INTERP_BITS);
		end
		res = ((x < 0) ? x : 0) - corr;
		if (res < -(longint'(1) << 31)) begin
			sat_seen = 1'b1;
			res = -(longint'(1) << 31);
		end
		return res;
	endfunction

	// Update the predicted state for one accepted word and queue its result, if any.
	function automatic void predict_word(input llacc_word_t w);
		longint        prod, eta, term;
		llacc_result_t r;
		if (w.kind == KIND_COEF) begin
			coef_mem[w.position] = w.value;
			return;
		end
		if (!sample_active) begin
			sample_active = 1'b1;
			sat_seen = 1'b0;
			lin_sum = longint'(coef_mem[0]);
		end
		if (!w.missing && w.position != 8'd0 && {1'b0, w.position} < fc_model) begin
			prod = longint'(w.value) * longint'(coef_mem[w.position]);
			lin_sum = clamp48(lin_sum + (prod >>> 16));
		end
		if (!w.last_feature)
			return;
		eta = lin_sum;
		if (w.label[1]) begin
			if (eta == longint'(SUM_MIN)) begin
				sat_seen = 1'b1;
				eta = longint'(SUM_MAX);
			end else begin
				eta = -eta;
			end
		end
		term = log_sigmoid_q16(eta);
		set_sum = clamp48(set_sum + term);
		r.term = term[31:0];
		r.total = set_sum[47:0];
		r.set_done = w.last_sample;
		r.saturated = sat_seen;
		expected_results.push_back(r);
		sample_active = 1'b0;
		lin_sum = 0;
		if (w.last_sample)
			set_sum = 0;
	endfunction

	// Random Q16.16 value: mostly near the interesting range of the curve.
	function automatic logic signed [31:0] rand_q16();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 65)
			return 32'(int'($urandom_range(262144)) - 131072);
		if (pick < 85)
			return 32'(int'($urandom_range(2097152)) - 1048576);
		if (pick < 95)
			return $urandom();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'h0001_0000;
			default: return 32'hFFFF_0000;
		endcase
	endfunction

	// Random word; positions lean toward the configured feature count.
	function automatic llacc_word_t random_word(input logic kind, input logic [8:0] fc);
		llacc_word_t w;
		int          pos_top;
		pos_top = (int'(fc) + 2 > 255) ? 255 : int'(fc) + 2;
		w.kind = kind;
		if ($urandom_range(99) < 75)
			w.position = 8'($urandom_range(pos_top));
		else
			w.position = 8'($urandom_range(255));
		w.value = rand_q16();
		w.missing = ($urandom_range(99) < 10);
		w.label = 2'($urandom_range(3));
		w.last_feature = 1'($urandom_range(1));
		w.last_sample = ($urandom_range(99) < 10);
		return w;
	endfunction

	// Offer one word, with random idle gaps before it, and predict once it is taken.
	task automatic send_word(input llacc_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= {5'b0, w.last_sample, w.label, w.value, w.position};
		s_axis_tuser <= {w.missing, w.kind};
		s_axis_tlast <= w.last_feature;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_word(w);
		words_sent++;
	endtask

	task automatic send_coef(input logic [7:0] pos, input logic signed [31:0] val);
		llacc_word_t w;
		w = '{kind: KIND_COEF, position: pos, value: val, missing: 1'b0,
			label: LABEL_PLUS, last_feature: 1'b0, last_sample: 1'b0};
		send_word(w);
	endtask

	task automatic send_feature(input logic [7:0] pos, input logic signed [31:0] val,
			input logic miss, input logic signed [1:0] lab, input logic lf, input logic ls);
		llacc_word_t w;
		w = '{kind: KIND_FEATURE, position: pos, value: val, missing: miss,
			label: lab, last_feature: lf, last_sample: ls};
		send_word(w);
	endtask

	// Let every expected result drain, then give the pipeline time to go quiet.
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_feature_count(input logic [8:0] fc);
		settle_block();
		cfg_data <= fc;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		fc_model = fc;
	endtask

	// Every coefficient is written before any feature can read it.
	task automatic test_coef_preload();
		int p;
		for (p = 0; p < 256; p++)
			send_coef(8'(p), rand_q16());
	endtask

	// Ignored positions, missing and repeated features, late coefficient writes.
	task automatic test_sample_rules();
		llacc_word_t w;
		write_feature_count(9'd8);
		send_coef(8'd0, 32'sh0001_8000);
		send_coef(8'd3, 32'sh0000_8000);
		// A coefficient word ignores its missing, label and last flags.
		w = '{kind: KIND_COEF, position: 8'd200, value: 32'sh0002_0000, missing: 1'b1,
			label: LABEL_MINUS, last_feature: 1'b1, last_sample: 1'b1};
		send_word(w);
		send_feature(8'd0, 32'sh0005_0000, 1'b0, LABEL_PLUS, 1'b0, 1'b0);
		send_feature(8'd3, 32'sh0002_0000, 1'b0, LABEL_MINUS, 1'b0, 1'b0);
		send_feature(8'd3, 32'sh0002_0000, 1'b1, LABEL_PLUS, 1'b0, 1'b0);
		send_feature(8'd3, -32'sh0001_0000, 1'b0, LABEL_PLUS, 1'b0, 1'b0);
		send_feature(8'd200, 32'sh0009_0000, 1'b0, LABEL_PLUS, 1'b0, 1'b0);
		send_feature(8'd5, 32'sh0001_0000, 1'b0, LABEL_MINUS, 1'b0, 1'b1);
		send_coef(8'd5, -32'sh0003_0000);
		send_feature(8'd5, 32'sh0001_0000, 1'b0, LABEL_PLUS, 1'b1, 1'b0);
		send_feature(8'd0, 32'sh0001_0000, 1'b1, LABEL_MINUS, 1'b1, 1'b1);
	endtask

	// Both label signs, a zero argument, and arguments far outside the curve.
	task automatic test_label_and_range();
		send_coef(8'd0, 32'sh0000_0000);
		send_feature(8'd0, 32'sh0000_0000, 1'b0, LABEL_MINUS, 1'b1, 1'b0);
		send_coef(8'd0, 32'sh0014_0000);
		send_feature(8'd0, 32'sh0000_0000, 1'b0, LABEL_ZERO, 1'b1, 1'b0);
		send_feature(8'd0, 32'sh0000_0000, 1'b0, LABEL_MINUS2, 1'b1, 1'b0);
		send_coef(8'd0, 32'h8000_0000);
		send_feature(8'd255, 32'sh7FFF_FFFF, 1'b0, LABEL_PLUS, 1'b1, 1'b0);
		send_feature(8'd0, 32'h8000_0000, 1'b0, LABEL_MINUS, 1'b1, 1'b1);
	endtask

	// Linear sum saturating high and low, then negated by a minus label.
	task automatic test_saturation();
		write_feature_count(9'd256);
		send_coef(8'd1, 32'sh7FFF_FFFF);
		repeat (2)
			send_feature(8'd1, 32'sh7FFF_FFFF, 1'b0, LABEL_PLUS, 1'b0, 1'b0);
		send_feature(8'd1, 32'sh7FFF_FFFF, 1'b0, LABEL_MINUS, 1'b1, 1'b0);
		send_coef(8'd1, 32'h8000_0000);
		repeat (2)
			send_feature(8'd1, 32'sh7FFF_FFFF, 1'b0, LABEL_PLUS, 1'b0, 1'b0);
		send_feature(8'd1, 32'sh7FFF_FFFF, 1'b0, LABEL_MINUS, 1'b1, 1'b1);
	endtask

	// Whole samples with random content, coefficient rewrites and stray flags.
	task automatic test_random_traffic(input logic [8:0] fc, input int send_pct,
			input int recv_pct, input int n_words);
		llacc_word_t w;
		int          first, n_feat, k;
		write_feature_count(fc);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		first = words_sent;
		while (words_sent - first < n_words) begin
			if ($urandom_range(99) < 12) begin
				w = random_word(KIND_COEF, fc);
				send_word(w);
			end
			n_feat = ($urandom_range(99) < 90) ? $urandom_range(1, 6) : $urandom_range(7, 20);
			for (k = 1; k <= n_feat; k++) begin
				w = random_word(KIND_FEATURE, fc);
				w.last_feature = (k == n_feat);
				if (k == n_feat)
					w.last_sample = ($urandom_range(99) < 25);
				send_word(w);
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// The output is held off for a long stretch while short samples keep coming.
	task automatic test_output_stall();
		llacc_word_t w;
		int          k;
		write_feature_count(9'd64);
		hold_req <= ~hold_req;
		for (k = 0; k < 80; k++) begin
			w = random_word(KIND_FEATURE, 9'd64);
			w.last_feature = (k == 79) || ($urandom_range(99) < 60);
			w.last_sample = w.last_feature && ($urandom_range(99) < 20);
			send_word(w);
		end
	endtask

	// Output ready: random stalls, or a counted hold-off on request.
	always @(posedge clk) begin : sink_ready
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result word with the oldest prediction.
	always @(posedge clk) begin : result_check
		llacc_result_t want;
		if (arst_n && s_axis_tvalid && !s_axis_tready)
			in_stalls++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tlast)
				sets_closed++;
			if (m_axis_tuser)
				sat_flagged++;
			if (expected_results.size() == 0) begin
				$error("result word with no prediction pending: term %0d total %0d",
					$signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[79:32]));
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== want.term) begin
					$error("sample_term: expected %0d, got %0d", want.term,
						$signed(m_axis_tdata[31:0]));
					errors++;
				end
				if (m_axis_tdata[79:32] !== want.total) begin
					$error("running_total: expected %0d, got %0d", want.total,
						$signed(m_axis_tdata[79:32]));
					errors++;
				end
				if (m_axis_tlast !== want.set_done) begin
					$error("set_done: expected %0b, got %0b", want.set_done, m_axis_tlast);
					errors++;
				end
				if (m_axis_tuser !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// Test sequence.
	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coef_preload();
		test_sample_rules();
		test_label_and_range();
		test_saturation();
		test_random_traffic(9'd256, 0, 0, 140);
		test_random_traffic(9'd1, 78, 0, 110);
		test_random_traffic(9'd2, 0, 78, 110);
		test_random_traffic(9'd255, 22, 22, 140);
		test_random_traffic(9'($urandom_range(3, 40)), 0, 0, 150);
		test_random_traffic(9'($urandom_range(1, 256)), 78, 0, 110);
		test_random_traffic(9'd16, 0, 78, 110);
		test_random_traffic(9'd256, 22, 22, 120);
		test_output_stall();
		settle_block();
		$display("Sent %0d words; checked %0d results, %0d closing a set, %0d saturated.",
			words_sent, results_seen, sets_closed, sat_flagged);
		$display("Feature counts from 1 to 256 under four idle mixes; input stalled %0d cycles.",
			in_stalls);
		if (errors == 0)
			$display("logistic_loglik_accumulator regression: pass");
		else
			$display("logistic_loglik_accumulator regression: fail");
		$finish;
	end

	// Watchdog for a hung handshake or a missing result.
	initial begin
		#(RUN_LIMIT_NS);
		$display("logistic_loglik_accumulator regression: fail");
		$finish;
	end

endmodule
